// ===== sv/bbt_pkg.sv =====
// Shared types and constants for the binary boundary tracer.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package bbt_pkg;

	// Command codes carried in the request.
	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_TRACE = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;
	localparam logic [1:0] CMD_NOP   = 2'd3;

	// Status codes reported in the response.
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_LIMIT = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;
	localparam logic [1:0] ST_RANGE = 2'd3;

	// Configuration register indexes.
	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_LIMIT  = 2'd2;

	localparam logic [8:0] DIM_RESET   = 9'd256;
	localparam logic [9:0] LIMIT_RESET = 10'd1000;
	localparam logic [7:0] FG_BYTE     = 8'd255;
	localparam logic [9:0] COUNT_MAX   = 10'd1023;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] pixel_x;
		logic [7:0] pixel_y;
		logic [7:0] pixel_value;
		logic [9:0] point_index;
	} req_t;

	typedef struct packed {
		logic [7:0] point_x;
		logic [7:0] point_y;
		logic [9:0] point_count;
		logic [1:0] status;
	} rsp_t;

	// Tracer status seen by the top level.
	typedef struct packed {
		logic       busy;
		logic       done;
		logic [1:0] status;
	} trc_stat_t;

endpackage

`default_nettype wire

// ===== sv/bbt_image_ram.sv =====
// Binary image memory: one row of pixels per word, single-bit writes,
// whole-row clears and a registered row read. Imports bbt_pkg but uses none of its items.
`timescale 1ns / 1ps
`default_nettype none

module bbt_image_ram import bbt_pkg::*; #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  wire logic                          clk,
	input  wire logic                          clr,
	input  wire logic                          we,
	input  wire logic [$clog2(MAX_HEIGHT)-1:0] waddr,
	input  wire logic [$clog2(MAX_WIDTH)-1:0]  wcol,
	input  wire logic                          wbit,
	input  wire logic                          re,
	input  wire logic [$clog2(MAX_HEIGHT)-1:0] raddr,
	output logic      [MAX_WIDTH-1:0]          rdata
);

	logic [MAX_WIDTH-1:0] mem [MAX_HEIGHT];

	always_ff @(posedge clk) begin
		if (clr) begin
			mem[waddr] <= '0;
		end else if (we) begin
			mem[waddr][wcol] <= wbit;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== sv/bbt_point_ram.sv =====
// Contour point store: one write port for the tracer, one registered read port.
// The read data holds between read enables. Imports bbt_pkg but uses none of its items.
`timescale 1ns / 1ps
`default_nettype none

module bbt_point_ram import bbt_pkg::*; #(
	parameter int DEPTH = 1024,
	parameter int DW    = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [DW-1:0]            wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [DW-1:0]            rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== sv/bbt_tracer.sv =====
// Start search and left-hand four-neighbor boundary-following sequencer. Reads image rows through the
// image memory port and writes turn points to the point store. Uses bbt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bbt_tracer import bbt_pkg::*; #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256,
	parameter int MAX_POINTS = 1024
) (
	input  wire logic                                              clk,
	input  wire logic                                              arst_n,
	input  wire logic                                              start,
	input  wire logic [8:0]                                        cfg_width,
	input  wire logic [8:0]                                        cfg_height,
	input  wire logic [9:0]                                        cfg_limit,
	output trc_stat_t                                              stat,
	output logic      [$clog2(MAX_POINTS+1)-1:0]                   length,
	output logic                                                   img_re,
	output logic      [$clog2(MAX_HEIGHT)-1:0]                     img_raddr,
	input  wire logic [MAX_WIDTH-1:0]                              img_rdata,
	output logic                                                   pt_we,
	output logic      [$clog2(MAX_POINTS)-1:0]                     pt_waddr,
	output logic      [$clog2(MAX_WIDTH)+$clog2(MAX_HEIGHT)-1:0]   pt_wdata
);

	localparam int XW = $clog2(MAX_WIDTH);
	localparam int YW = $clog2(MAX_HEIGHT);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int PW = $clog2(MAX_POINTS);
	localparam int LW = $clog2(MAX_POINTS + 1);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_ROW_RD = 4'd1;
	localparam logic [3:0] S_ROW_CK = 4'd2;
	localparam logic [3:0] S_COL    = 4'd3;
	localparam logic [3:0] S_STEP   = 4'd4;
	localparam logic [3:0] S_PRB_RD = 4'd5;
	localparam logic [3:0] S_PRB_CK = 4'd6;
	localparam logic [3:0] S_FIN    = 4'd7;

	// Heading codes; adding one turns right, y grows downward.
	localparam logic [1:0] DIR_E = 2'd0;
	localparam logic [1:0] DIR_S = 2'd1;
	localparam logic [1:0] DIR_W = 2'd2;
	localparam logic [1:0] DIR_N = 2'd3;

	localparam logic [1:0] PRB_LEFT  = 2'd0;
	localparam logic [1:0] PRB_RIGHT = 2'd2;
	localparam logic [1:0] PRB_BACK  = 2'd3;

	logic [3:0]    state_q;
	logic [YW-1:0] row_q;
	logic [XW-1:0] col_q;
	logic [XW-1:0] cx_q, sx_q, last_x_q;
	logic [YW-1:0] cy_q, sy_q, last_y_q;
	logic [1:0]    dir_q;
	logic [1:0]    probe_q;
	logic [9:0]    moves_q;
	logic [9:0]    limit_q;
	logic [LW-1:0] len_q;
	logic [1:0]    status_q;
	logic [WW-1:0] w_q;
	logic [HW-1:0] h_q;

	logic [WW-1:0]        w_clamp;
	logic [HW-1:0]        h_clamp;
	logic [MAX_WIDTH-1:0] wmask;
	logic                 row_any;
	logic [YW:0]          row_nxt;
	logic [1:0]           cand_dir;
	logic [XW:0]          cand_x;
	logic [YW:0]          cand_y;
	logic                 cand_in;
	logic                 cand_fore;
	logic                 cand_start;
	logic                 rec_req;
	logic [XW-1:0]        rec_x;
	logic [YW-1:0]        rec_y;
	logic                 store_room;

	// A zero dimension acts as one; anything past the storage acts as the storage size.
	always_comb begin
		if (cfg_width == 9'd0) begin
			w_clamp = WW'(1);
		end else if (32'(cfg_width) > MAX_WIDTH) begin
			w_clamp = WW'(MAX_WIDTH);
		end else begin
			w_clamp = WW'(cfg_width);
		end
		if (cfg_height == 9'd0) begin
			h_clamp = HW'(1);
		end else if (32'(cfg_height) > MAX_HEIGHT) begin
			h_clamp = HW'(MAX_HEIGHT);
		end else begin
			h_clamp = HW'(cfg_height);
		end
	end

	always_comb begin
		for (int i = 0; i < MAX_WIDTH; i++) begin
			wmask[i] = (32'(i) < 32'(w_q));
		end
	end

	assign row_any = |(img_rdata & wmask);
	assign row_nxt = (YW+1)'(row_q) + (YW+1)'(1);

	// Probe order left, straight, right, back maps to heading offsets 3, 0, 1, 2.
	assign cand_dir = dir_q + probe_q + 2'd3;

	always_comb begin
		cand_x = (XW+1)'(cx_q);
		cand_y = (YW+1)'(cy_q);
		unique case (cand_dir)
			DIR_E: cand_x = (XW+1)'(cx_q) + (XW+1)'(1);
			DIR_S: cand_y = (YW+1)'(cy_q) + (YW+1)'(1);
			DIR_W: cand_x = (XW+1)'(cx_q) - (XW+1)'(1);
			DIR_N: cand_y = (YW+1)'(cy_q) - (YW+1)'(1);
			default: cand_x = (XW+1)'(cx_q);
		endcase
	end

	// A step off the low edge wraps to all ones, which also fails the bound check.
	assign cand_in    = (cand_x < (XW+1)'(w_q)) && (cand_y < (YW+1)'(h_q));
	assign cand_fore  = cand_in && img_rdata[cand_x[XW-1:0]];
	assign cand_start = (cand_x[XW-1:0] == sx_q) && (cand_y[YW-1:0] == sy_q);

	always_comb begin
		rec_req = 1'b0;
		rec_x   = cx_q;
		rec_y   = cy_q;
		if (state_q == S_COL && img_rdata[col_q]) begin
			rec_req = 1'b1;
			rec_x   = col_q;
			rec_y   = row_q;
		end else if (state_q == S_PRB_CK && cand_fore &&
				(probe_q == PRB_LEFT || probe_q == PRB_RIGHT) &&
				(cx_q != last_x_q || cy_q != last_y_q)) begin
			rec_req = 1'b1;
		end
	end

	assign store_room = (32'(len_q) < MAX_POINTS);
	assign pt_we      = rec_req && store_room;
	assign pt_waddr   = PW'(len_q);
	assign pt_wdata   = {rec_y, rec_x};

	assign img_re    = (state_q == S_ROW_RD) || (state_q == S_PRB_RD);
	assign img_raddr = (state_q == S_PRB_RD) ? cand_y[YW-1:0] : row_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			len_q    <= '0;
			status_q <= ST_EMPTY;
		end else begin
			if (pt_we) begin
				len_q <= len_q + LW'(1);
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						len_q   <= '0;
						state_q <= S_ROW_RD;
					end
				end
				S_ROW_RD: begin
					state_q <= S_ROW_CK;
				end
				S_ROW_CK: begin
					if (row_any) begin
						state_q <= S_COL;
					end else if (row_nxt == (YW+1)'(h_q)) begin
						status_q <= ST_EMPTY;
						state_q  <= S_FIN;
					end else begin
						state_q <= S_ROW_RD;
					end
				end
				S_COL: begin
					if (img_rdata[col_q]) begin
						status_q <= ST_OK;
						state_q  <= S_STEP;
					end
				end
				S_STEP: begin
					if (moves_q == limit_q) begin
						status_q <= ST_LIMIT;
						state_q  <= S_FIN;
					end else begin
						state_q <= S_PRB_RD;
					end
				end
				S_PRB_RD: begin
					state_q <= S_PRB_CK;
				end
				S_PRB_CK: begin
					if (cand_fore) begin
						state_q <= cand_start ? S_FIN : S_STEP;
					end else if (probe_q == PRB_BACK) begin
						state_q <= S_FIN;
					end else begin
						state_q <= S_PRB_RD;
					end
				end
				S_FIN: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Walk position, heading and counters.
	always_ff @(posedge clk) begin
		if (pt_we) begin
			last_x_q <= rec_x;
			last_y_q <= rec_y;
		end
		case (state_q)
			S_IDLE: begin
				w_q     <= w_clamp;
				h_q     <= h_clamp;
				limit_q <= cfg_limit;
				row_q   <= '0;
			end
			S_ROW_CK: begin
				col_q <= '0;
				if (!row_any) begin
					row_q <= row_nxt[YW-1:0];
				end
			end
			S_COL: begin
				col_q   <= col_q + XW'(1);
				sx_q    <= col_q;
				sy_q    <= row_q;
				cx_q    <= col_q;
				cy_q    <= row_q;
				dir_q   <= DIR_E;
				moves_q <= '0;
			end
			S_STEP: begin
				moves_q <= moves_q + 10'd1;
				probe_q <= PRB_LEFT;
			end
			S_PRB_CK: begin
				probe_q <= probe_q + 2'd1;
				if (cand_fore) begin
					cx_q  <= cand_x[XW-1:0];
					cy_q  <= cand_y[YW-1:0];
					dir_q <= cand_dir;
				end
			end
			default: begin
			end
		endcase
	end

	assign stat.busy   = (state_q != S_IDLE);
	assign stat.done   = (state_q == S_FIN);
	assign stat.status = status_q;
	assign length      = len_q;

endmodule

`default_nettype wire

// ===== sv/binary_boundary_tracer_core.sv =====
// Top level of the binary boundary tracer: handshakes, configuration registers,
// image clearing pass and response register. Uses bbt_pkg and the bbt_* modules.
//
//   channel  | direction | handshake           | payload
//   ---------+-----------+---------------------+-------------------------------
//   request  | in        | req_valid/req_ready | req (req_t)
//   response | out       | rsp_valid/rsp_ready | rsp (rsp_t)
//   config   | in        | cfg_we              | cfg_index, cfg_wdata
//
// A new pixel write, point read or no-op may be taken each cycle while responses are taken.
// A trace reads the rows one at a time down to the start row, then scans that row column by
// column up to the start pixel, then for each move does one limit check and up to four
// neighbor probes, each probe being one read of the image row memory.
// After reset the image memory is cleared one row per cycle, with req_ready held low
// until every row is clear. A stalled response holds the request side only while it is full.
`timescale 1ns / 1ps
`default_nettype none

module binary_boundary_tracer_core import bbt_pkg::*; #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256,
	parameter int MAX_POINTS = 1024
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       req_valid,
	output logic            req_ready,
	input  wire req_t       req,
	output logic            rsp_valid,
	input  wire logic       rsp_ready,
	output rsp_t            rsp,
	input  wire logic       cfg_we,
	input  wire logic [1:0] cfg_index,
	input  wire logic [9:0] cfg_wdata
);

	localparam int XW = $clog2(MAX_WIDTH);
	localparam int YW = $clog2(MAX_HEIGHT);
	localparam int PW = $clog2(MAX_POINTS);
	localparam int LW = $clog2(MAX_POINTS + 1);

	logic [8:0]    width_q;
	logic [8:0]    height_q;
	logic [9:0]    limit_q;
	logic          clr_q;
	logic [YW-1:0] clr_row_q;

	logic          rsp_valid_q;
	logic [9:0]    rsp_count_q;
	logic [1:0]    rsp_status_q;
	logic          rsp_ram_q;

	logic          req_fire;
	logic          pix_in;
	logic          img_we;
	logic          rd_ok;
	logic [9:0]    count_sat;

	trc_stat_t         trc;
	logic [LW-1:0]     trc_len;
	logic              img_re;
	logic [YW-1:0]     img_raddr;
	logic [MAX_WIDTH-1:0] img_rdata;
	logic              pt_we;
	logic [PW-1:0]     pt_waddr;
	logic [XW+YW-1:0]  pt_wdata;
	logic              pt_re;
	logic [XW+YW-1:0]  pt_rdata;

	assign req_ready = !clr_q && !trc.busy && (!rsp_valid_q || rsp_ready);
	assign req_fire  = req_valid && req_ready;

	assign pix_in = (32'(req.pixel_x) < MAX_WIDTH) && (32'(req.pixel_y) < MAX_HEIGHT);
	assign img_we = req_fire && (req.cmd == CMD_WRITE) && pix_in;

	assign rd_ok     = (32'(req.point_index) < 32'(trc_len));
	assign pt_re     = req_fire && (req.cmd == CMD_READ);
	assign count_sat = (32'(trc_len) > 32'(COUNT_MAX)) ? COUNT_MAX : 10'(trc_len);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_RESET;
			height_q <= DIM_RESET;
			limit_q  <= LIMIT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_wdata[8:0];
				REG_HEIGHT: height_q <= cfg_wdata[8:0];
				REG_LIMIT:  limit_q  <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// Clearing pass over the image rows after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_row_q <= '0;
		end else if (clr_q) begin
			clr_row_q <= clr_row_q + YW'(1);
			if (clr_row_q == YW'(MAX_HEIGHT - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if ((req_fire && req.cmd != CMD_TRACE) || trc.done) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (trc.done) begin
			rsp_count_q  <= count_sat;
			rsp_status_q <= trc.status;
			rsp_ram_q    <= 1'b0;
		end else if (req_fire && req.cmd != CMD_TRACE) begin
			rsp_count_q <= count_sat;
			if (req.cmd == CMD_READ) begin
				rsp_ram_q    <= rd_ok;
				rsp_status_q <= rd_ok ? ST_OK : ST_RANGE;
			end else begin
				rsp_ram_q    <= 1'b0;
				rsp_status_q <= trc.status;
			end
		end
	end

	// The point store read data holds until the next read transfer, which cannot
	// be taken before this response leaves.
	assign rsp_valid         = rsp_valid_q;
	assign rsp.point_x       = rsp_ram_q ? 8'(pt_rdata[XW-1:0]) : 8'd0;
	assign rsp.point_y       = rsp_ram_q ? 8'(pt_rdata[XW+YW-1:XW]) : 8'd0;
	assign rsp.point_count   = rsp_count_q;
	assign rsp.status        = rsp_status_q;

	bbt_image_ram #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_image (
		.clk   (clk),
		.clr   (clr_q),
		.we    (img_we),
		.waddr (clr_q ? clr_row_q : YW'(req.pixel_y)),
		.wcol  (XW'(req.pixel_x)),
		.wbit  (req.pixel_value == FG_BYTE),
		.re    (img_re),
		.raddr (img_raddr),
		.rdata (img_rdata)
	);

	bbt_point_ram #(
		.DEPTH (MAX_POINTS),
		.DW    (XW + YW)
	) u_points (
		.clk   (clk),
		.we    (pt_we),
		.waddr (pt_waddr),
		.wdata (pt_wdata),
		.re    (pt_re),
		.raddr (PW'(req.point_index)),
		.rdata (pt_rdata)
	);

	bbt_tracer #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.MAX_POINTS (MAX_POINTS)
	) u_tracer (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (req_fire && req.cmd == CMD_TRACE),
		.cfg_width  (width_q),
		.cfg_height (height_q),
		.cfg_limit  (limit_q),
		.stat       (trc),
		.length     (trc_len),
		.img_re     (img_re),
		.img_raddr  (img_raddr),
		.img_rdata  (img_rdata),
		.pt_we      (pt_we),
		.pt_waddr   (pt_waddr),
		.pt_wdata   (pt_wdata)
	);

`ifndef SYNTHESIS
	// A finished trace must find the response register empty.
	a_done_rsp_free: assert property (@(posedge clk) disable iff (!arst_n)
		trc.done |-> !rsp_valid_q)
		else $error("trace finished while a response was pending");

	// A point read answers in the following cycle.
	a_read_answers: assert property (@(posedge clk) disable iff (!arst_n)
		(req_fire && req.cmd == CMD_READ) |=> rsp_valid)
		else $error("point read produced no response");

	// The contour length never passes the store size.
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		trc_len <= LW'(MAX_POINTS))
		else $error("contour length beyond store size");

	// An empty result always comes with no points.
	a_empty_len: assert property (@(posedge clk) disable iff (!arst_n)
		(!trc.busy && trc.status == ST_EMPTY) |-> (trc_len == '0))
		else $error("empty status with nonzero length");
`endif

endmodule

`default_nettype wire
